// ----- src/tcce_pkg.sv -----
// shared types and constants for the text console character engine
package tcce_pkg;

   // request operation codes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_SET   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // character codes handled by put character
   localparam logic [7:0] CHAR_BS       = 8'h08;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
   localparam logic [7:0] CHAR_PRINT_HI = 8'h7F;

   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h0F;
   localparam int         TAB_STEP   = 8;

   // field widths of the request and response
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int TCOL_W = 7;
   localparam int TLINE_W = 5;
   localparam int CELL_W = 16;
   localparam int POS_W = 11;

   typedef enum logic [1:0] {
      SW_NONE,
      SW_COPY,
      SW_FILL_ATTR,
      SW_FILL_RESET
   } sweep_type;

   typedef struct packed {
      logic      take_req;
      logic      exec_put;
      logic      set_cursor;
      logic      home;
      logic      read_issue;
      logic      read_capture;
      logic      load_rsp;
      sweep_type sweep;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       put_scroll;
      logic       sweep_last;
      logic       rsp_free;
   } status_type;

endpackage

// ----- src/tcce_ram.sv -----
// generic single write port, single read port ram with registered read
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/tcce_ctrl.sv -----
// sequencing state machine for the text console character engine
module tcce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tcce_pkg::status_type status,
   output tcce_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ_WAIT,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   tcce_pkg::sweep_type mode_ff, mode_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.sweep = tcce_pkg::SW_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (status.op)
               tcce_pkg::OP_PUT: begin
                  cmd.exec_put = 1'b1;
                  if (status.put_scroll) begin
                     mode_in  = tcce_pkg::SW_COPY;
                     state_in = ST_SWEEP;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
               tcce_pkg::OP_READ: begin
                  cmd.read_issue = 1'b1;
                  state_in       = ST_READ_WAIT;
               end
               tcce_pkg::OP_SET: begin
                  cmd.set_cursor = 1'b1;
                  state_in       = ST_FINISH;
               end
               tcce_pkg::OP_CLEAR: begin
                  cmd.home = 1'b1;
                  mode_in  = tcce_pkg::SW_FILL_ATTR;
                  state_in = ST_SWEEP;
               end
            endcase
         end
         ST_READ_WAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_FINISH;
         end
         ST_SWEEP: begin
            cmd.sweep = mode_ff;
            if (status.sweep_last) begin
               // the power-up fill has no request behind it
               state_in = (mode_ff == tcce_pkg::SW_FILL_RESET) ? ST_IDLE : ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         mode_ff  <= tcce_pkg::SW_FILL_RESET;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

// ----- src/tcce_dp.sv -----
// datapath: cursor, attribute, screen store, sweep counter and response register
module tcce_dp #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_operation,
   input  logic [tcce_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [tcce_pkg::TCOL_W-1:0]       req_target_column,
   input  logic [tcce_pkg::TLINE_W-1:0]      req_target_line,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [tcce_pkg::CELL_W-1:0]       rsp_cell_value,
   output logic [tcce_pkg::TCOL_W-1:0]       rsp_cursor_column,
   output logic [tcce_pkg::TLINE_W-1:0]      rsp_cursor_line,
   output logic [tcce_pkg::POS_W-1:0]        rsp_cursor_position,
   input  logic                              csr_wr_en,
   input  logic [tcce_pkg::ATTR_W-1:0]       csr_wr_data,
   input  tcce_pkg::cmd_type                 cmd,
   output tcce_pkg::status_type              status
);

   localparam int CELLS    = COLUMNS * ROWS;
   localparam int AW       = $clog2(CELLS);
   localparam int CW       = $clog2(COLUMNS);
   localparam int CXW      = CW + 1;
   localparam int LW       = $clog2(ROWS);
   localparam int COPY_CNT = (ROWS - 1) * COLUMNS;

   localparam logic [AW-1:0]  COLS_A   = AW'(COLUMNS);
   localparam logic [AW-1:0]  LAST_A   = AW'(CELLS - 1);
   localparam logic [AW-1:0]  COPY_A   = AW'(COPY_CNT);
   localparam logic [CW-1:0]  COL_MAX  = CW'(COLUMNS - 1);
   localparam logic [LW-1:0]  LINE_MAX = LW'(ROWS - 1);
   localparam logic [CXW-1:0] COLS_X   = CXW'(COLUMNS);
   localparam logic [CXW-1:0] TAB_X    = CXW'(tcce_pkg::TAB_STEP);
   localparam logic [CXW-1:0] TAB_MASK = ~CXW'(tcce_pkg::TAB_STEP - 1);

   localparam logic [tcce_pkg::CELL_W-1:0] RESET_BLANK =
      {tcce_pkg::RESET_ATTR, tcce_pkg::BLANK_CHAR};

   function automatic logic [AW-1:0] cell_addr(input logic [LW-1:0] line,
                                               input logic [CW-1:0] col);
      return AW'(line) * COLS_A + AW'(col);
   endfunction

   // latched request
   logic [1:0]                     op_ff;
   logic [tcce_pkg::CHAR_W-1:0]    char_ff;
   logic [tcce_pkg::TCOL_W-1:0]    tcol_ff;
   logic [tcce_pkg::TLINE_W-1:0]   tline_ff;

   logic [CW-1:0]                  col_ff, col_in;
   logic [LW-1:0]                  line_ff, line_in;
   logic [tcce_pkg::ATTR_W-1:0]    attr_ff;

   logic [AW-1:0]                  sw_ff, sw_in;
   logic                           pend_ff, pend_in;
   logic [AW-1:0]                  pend_addr_ff;
   logic                           pend_use_rd_ff, pend_use_rd_in;
   logic [tcce_pkg::CELL_W-1:0]    pend_val_ff, pend_val_in;

   logic                           rd_ok_ff;
   logic [tcce_pkg::CELL_W-1:0]    cell_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tcce_pkg::CELL_W-1:0]    rsp_cell_ff;
   logic [tcce_pkg::TCOL_W-1:0]    rsp_col_ff;
   logic [tcce_pkg::TLINE_W-1:0]   rsp_line_ff;
   logic [tcce_pkg::POS_W-1:0]     rsp_pos_ff;

   logic [CXW-1:0]                 col_x, col_nx;
   logic                           line_inc;
   logic                           printable;
   logic                           put_scroll;
   logic [LW-1:0]                  line_put;
   logic                           tcol_ok, tline_ok;
   logic [AW-1:0]                  target_addr;

   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr, ram_raddr;
   logic [tcce_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;
   logic [tcce_pkg::CELL_W-1:0]    attr_blank;

   assign attr_blank = {attr_ff, tcce_pkg::BLANK_CHAR};

   // put character: next column and line advance
   assign col_x = CXW'(col_ff);

   always_comb begin
      col_nx    = col_x;
      line_inc  = 1'b0;
      printable = 1'b0;
      case (char_ff) inside
         tcce_pkg::CHAR_BS: begin
            if (col_ff != '0) begin
               col_nx = col_x - 1'b1;
            end
         end
         tcce_pkg::CHAR_TAB: begin
            col_nx = (col_x + TAB_X) & TAB_MASK;
         end
         tcce_pkg::CHAR_CR: begin
            col_nx = '0;
         end
         tcce_pkg::CHAR_LF: begin
            col_nx   = '0;
            line_inc = 1'b1;
         end
         [tcce_pkg::CHAR_PRINT_LO:tcce_pkg::CHAR_PRINT_HI]: begin
            printable = 1'b1;
            col_nx    = col_x + 1'b1;
         end
         default: begin
            col_nx = col_x;
         end
      endcase
      // wrap past the right edge
      if (col_nx >= COLS_X) begin
         col_nx   = '0;
         line_inc = 1'b1;
      end
   end

   assign put_scroll = line_inc && (line_ff == LINE_MAX);
   assign line_put   = put_scroll ? LINE_MAX : line_ff + LW'(line_inc);

   // target checks for set cursor and read cell
   assign tcol_ok     = (8'(tcol_ff) < 8'(COLUMNS));
   assign tline_ok    = (7'(tline_ff) < 7'(ROWS));
   assign target_addr = cell_addr(LW'(tline_ff), CW'(tcol_ff));

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (cmd.exec_put) begin
         col_in  = CW'(col_nx);
         line_in = line_put;
      end else if (cmd.set_cursor) begin
         col_in  = tcol_ok ? CW'(tcol_ff) : COL_MAX;
         line_in = tline_ok ? LW'(tline_ff) : LINE_MAX;
      end else if (cmd.home) begin
         col_in  = '0;
         line_in = '0;
      end
   end

   // sweep over the whole store: read one row ahead, write in the cycle after
   always_comb begin
      sw_in          = (cmd.sweep != tcce_pkg::SW_NONE) ? sw_ff + 1'b1 : '0;
      pend_in        = (cmd.sweep != tcce_pkg::SW_NONE);
      pend_use_rd_in = (cmd.sweep == tcce_pkg::SW_COPY) && (sw_ff < COPY_A);
      pend_val_in    = (cmd.sweep == tcce_pkg::SW_FILL_RESET) ? RESET_BLANK : attr_blank;
   end

   assign ram_raddr = (cmd.sweep == tcce_pkg::SW_COPY) ? sw_ff + COLS_A : target_addr;
   assign ram_we    = pend_ff || (cmd.exec_put && printable);
   assign ram_waddr = pend_ff ? pend_addr_ff : cell_addr(line_ff, col_ff);
   assign ram_wdata = pend_ff ? (pend_use_rd_ff ? ram_rdata : pend_val_ff)
                              : {attr_ff, char_ff};

   tcce_ram #(
      .WIDTH (tcce_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         line_ff      <= '0;
         attr_ff      <= tcce_pkg::RESET_ATTR;
         sw_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         line_ff      <= line_in;
         sw_ff        <= sw_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff   <= sw_ff;
      pend_use_rd_ff <= pend_use_rd_in;
      pend_val_ff    <= pend_val_in;
      if (cmd.take_req) begin
         op_ff    <= req_operation;
         char_ff  <= req_char_code;
         tcol_ff  <= req_target_column;
         tline_ff <= req_target_line;
         cell_ff  <= '0;
      end
      if (cmd.read_issue) begin
         rd_ok_ff <= tcol_ok && tline_ok;
      end
      if (cmd.read_capture) begin
         cell_ff <= rd_ok_ff ? ram_rdata : '0;
      end
      if (cmd.load_rsp) begin
         rsp_cell_ff <= cell_ff;
         rsp_col_ff  <= tcce_pkg::TCOL_W'(col_ff);
         rsp_line_ff <= tcce_pkg::TLINE_W'(line_ff);
         rsp_pos_ff  <= tcce_pkg::POS_W'(cell_addr(line_ff, col_ff));
      end
   end

   assign status.op         = op_ff;
   assign status.put_scroll = put_scroll;
   assign status.sweep_last = (sw_ff == LAST_A);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_value      = rsp_cell_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_line     = rsp_line_ff;
   assign rsp_cursor_position = rsp_pos_ff;

endmodule

// ----- src/text_console_char_engine_core.sv -----
// top level of the text console character engine
//
// A COLUMNS x ROWS screen of 16-bit cells (attribute in the high byte, character
// in the low byte) with a cursor, held in one single-port-write ram. Each
// request gives exactly one response with the cursor after the operation. One
// request is worked at a time, and requests are taken only in the idle state: a
// put character or set cursor passes through the exec and finish states before
// the next acceptance, a read cell through exec, read wait and finish (one ram
// read with registered output). A put that runs past the last line scrolls, and
// a clear fills the screen; both sweep the ram one cell per cycle. After reset a
// fill pass writes blank cells with attribute 0x0F before the first request is
// accepted; attribute writes are taken during that pass. The response sits in
// an output register, so a waiting response does not stop the next request
// from being accepted and worked.
module text_console_char_engine_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [tcce_pkg::CHAR_W-1:0]  req_char_code,
   input  logic [tcce_pkg::TCOL_W-1:0]  req_target_column,
   input  logic [tcce_pkg::TLINE_W-1:0] req_target_line,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tcce_pkg::CELL_W-1:0]  rsp_cell_value,
   output logic [tcce_pkg::TCOL_W-1:0]  rsp_cursor_column,
   output logic [tcce_pkg::TLINE_W-1:0] rsp_cursor_line,
   output logic [tcce_pkg::POS_W-1:0]   rsp_cursor_position,
   input  logic                         csr_wr_en,
   input  logic [tcce_pkg::ATTR_W-1:0]  csr_wr_data
);

   tcce_pkg::cmd_type    cmd;
   tcce_pkg::status_type status;

   tcce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcce_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_operation       (req_operation),
      .req_char_code       (req_char_code),
      .req_target_column   (req_target_column),
      .req_target_line     (req_target_line),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_cell_value      (rsp_cell_value),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_line     (rsp_cursor_line),
      .rsp_cursor_position (rsp_cursor_position),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule
